// ===== hw/rtl/tcfe_pkg.sv =====
// Shared types and constants for the TDM channel frame extractor.
package tcfe_pkg;

    localparam int SLOTS       = 12;
    localparam int WORD_W      = 32;
    localparam int FILL_W      = 4;
    localparam int TAG_LSB     = 8;
    localparam int TAG_W       = 4;
    localparam int SAMPLE_LSB  = 16;
    localparam int SAMPLE_W    = 16;
    localparam int FRAME_WORDS = 3;
    localparam int BEAT_W      = 2;
    localparam int ADDR_W      = 3;
    localparam int ADDR_LSB    = 2;

    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(SLOTS - 1);
    localparam logic [BEAT_W-1:0] BEAT_LAST = BEAT_W'(FRAME_WORDS - 1);

    // Register index, taken from the word address
    typedef enum logic [0:0] {
        REG_TAG_CHECK = 1'b0
    } t_reg_idx;

    // Three packed output words of one frame, beat 0 sent first
    typedef struct packed {
        logic                  valid;
        logic [WORD_W-1:0]     beat2;
        logic [WORD_W-1:0]     beat1;
        logic [WORD_W-1:0]     beat0;
    } t_frame;

    function automatic logic [WORD_W-1:0] pack_pair(input logic [WORD_W-1:0] hi_word,
                                                    input logic [WORD_W-1:0] lo_word);
        pack_pair = {hi_word[SAMPLE_LSB +: SAMPLE_W], lo_word[SAMPLE_LSB +: SAMPLE_W]};
    endfunction

endpackage

// ===== hw/rtl/tdm_channel_frame_extractor.sv =====
// Top level: TDM 12-slot frame extractor with APB control.
//
//  channel  | dir | transfer unit          | payload
//  s_axis   | in  | one slot word          | tdata[31:0] sample_word
//  m_axis   | out | one packed word        | tdata[31:0] packed_word, tlast frame_last
//  apb      | cfg | register access        | reg 0 at 0x0: tag_check_enable
//
// One slot word is taken per cycle while s_axis_tready is high; a frame's first result
// shows the cycle after the twelfth word; its three beats go out in order, beat 0 first.
// The output holds one frame; s_axis_tready drops only while a frame is still queued
// and the next word would complete the window.
// Synchronous active-low reset empties the window and output, and sets tag checking on.
module tdm_channel_frame_extractor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [tcfe_pkg::WORD_W-1:0] s_axis_tdata,   // [31:0] sample_word
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [tcfe_pkg::WORD_W-1:0] m_axis_tdata,   // [31:0] packed_word
    output logic                        m_axis_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcfe_pkg::ADDR_W-1:0] paddr,
    input  logic [tcfe_pkg::WORD_W-1:0] pwdata,
    output logic [tcfe_pkg::WORD_W-1:0] prdata,
    output logic                        pready
);
    import tcfe_pkg::*;

    logic   tag_check_en;
    logic   fill_last;
    logic   can_load;
    logic   word_valid;
    t_frame frame;

    tcfe_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_tag_check_en (tag_check_en)
    );

    assign s_axis_tready = ~fill_last | can_load;
    assign word_valid    = s_axis_tvalid & s_axis_tready;

    tcfe_window u_window (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_word_valid   (word_valid),
        .i_word         (s_axis_tdata),
        .i_tag_check_en (tag_check_en),
        .o_fill_last    (fill_last),
        .o_frame        (frame)
    );

    tcfe_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame       (frame),
        .o_can_load    (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== hw/rtl/tcfe_cfg.sv =====
// APB register block holding the tag check enable.
module tcfe_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcfe_pkg::ADDR_W-1:0]   paddr,
    input  logic [tcfe_pkg::WORD_W-1:0]   pwdata,
    output logic [tcfe_pkg::WORD_W-1:0]   prdata,
    output logic                          pready,
    output logic                          o_tag_check_en
);
    import tcfe_pkg::*;

    logic     r_tag_check_en;
    logic     n_tag_check_en;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[ADDR_LSB]);
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;

    always_comb begin
        n_tag_check_en = r_tag_check_en;
        prdata         = '0;
        case (reg_idx)
            REG_TAG_CHECK: begin
                prdata = {{(WORD_W-1){1'b0}}, r_tag_check_en};
                if (wr_en) begin
                    n_tag_check_en = pwdata[0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_check_en <= 1'b1;
        end else begin
            r_tag_check_en <= n_tag_check_en;
        end
    end

    assign o_tag_check_en = r_tag_check_en;

endmodule

// ===== hw/rtl/tcfe_window.sv =====
// Slot window shift line, fill count and tag check; builds a frame on a match or on any full window with checking off.
module tcfe_window (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_word_valid,
    input  logic [tcfe_pkg::WORD_W-1:0] i_word,
    input  logic                        i_tag_check_en,
    output logic                        o_fill_last,
    output tcfe_pkg::t_frame            o_frame
);
    import tcfe_pkg::*;

    // Newest word at the top; the last r_fill words make up the window
    logic [WORD_W-1:0] r_win [SLOTS];
    logic [WORD_W-1:0] n_win [SLOTS];
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [SLOTS-1:0]  tag_ok;
    logic              frame_hit;

    always_comb begin
        for (int i = 0; i < SLOTS - 1; i++) begin
            n_win[i] = r_win[i+1];
        end
        n_win[SLOTS-1] = i_word;
    end

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            tag_ok[i] = (n_win[i][TAG_LSB +: TAG_W] == TAG_W'(i + 1));
        end
    end

    assign o_fill_last = (r_fill == FILL_LAST);
    assign frame_hit   = i_word_valid & o_fill_last & (~i_tag_check_en | (&tag_ok));

    always_comb begin
        n_fill = r_fill;
        if (i_word_valid) begin
            if (frame_hit) begin
                n_fill = '0;
            end else if (!o_fill_last) begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    always_comb begin
        o_frame.valid = frame_hit;
        o_frame.beat0 = pack_pair(n_win[0], n_win[1]);
        o_frame.beat1 = pack_pair(n_win[6], n_win[7]);
        o_frame.beat2 = pack_pair(n_win[3], n_win[9]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_word_valid) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

endmodule

// ===== hw/rtl/tcfe_out.sv =====
// Frame result register sending three packed words as a stream.
module tcfe_out (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tcfe_pkg::t_frame            i_frame,
    output logic                        o_can_load,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [tcfe_pkg::WORD_W-1:0] m_axis_tdata,
    output logic                        m_axis_tlast
);
    import tcfe_pkg::*;

    logic [WORD_W-1:0] r_beat [FRAME_WORDS];
    logic              r_busy;
    logic [BEAT_W-1:0] r_idx;
    logic              n_busy;
    logic [BEAT_W-1:0] n_idx;
    logic              beat_done;
    logic              last_done;

    assign beat_done  = r_busy & m_axis_tready;
    assign last_done  = beat_done & (r_idx == BEAT_LAST);
    assign o_can_load = ~r_busy | last_done;

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (beat_done) begin
            n_idx = r_idx + 1'b1;
        end
        if (last_done) begin
            n_busy = 1'b0;
            n_idx  = '0;
        end
        if (i_frame.valid) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.valid) begin
            r_beat[0] <= i_frame.beat0;
            r_beat[1] <= i_frame.beat1;
            r_beat[2] <= i_frame.beat2;
        end
    end

    assign m_axis_tvalid = r_busy;
    assign m_axis_tdata  = r_beat[r_idx];
    assign m_axis_tlast  = (r_idx == BEAT_LAST);

endmodule

// ===== sim/tdm_channel_frame_extractor_checker.sv =====
`timescale 1ns / 1ps
// Checker for the TDM frame extractor: tracks the slot window and compares packed output words.
module tdm_channel_frame_extractor_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tready,
    input  logic [tcfe_pkg::WORD_W-1:0] i_s_tdata,    // [31:0] sample_word
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    input  logic [tcfe_pkg::WORD_W-1:0] i_m_tdata,    // [31:0] packed_word
    input  logic                        i_m_tlast,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [tcfe_pkg::ADDR_W-1:0] i_paddr,
    input  logic [tcfe_pkg::WORD_W-1:0] i_pwdata,
    input  logic [tcfe_pkg::WORD_W-1:0] i_prdata,
    input  logic                        i_pready,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_words_checked,
    output int                          o_slides
);
    import tcfe_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } t_packed_beat;

    logic [WORD_W-1:0] slot_win [SLOTS];
    int                win_fill     = 0;
    logic              tag_check_on = 1'b1;
    t_packed_beat      beats_due [$];
    int                fails        = 0;
    int                checked      = 0;
    int                slides       = 0;

    function automatic logic tags_in_order();
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_win[i][TAG_LSB +: TAG_W] != TAG_W'(i + 1))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [WORD_W-1:0] join_samples(input int hi_slot, input int lo_slot);
        return {slot_win[hi_slot][SAMPLE_LSB +: SAMPLE_W],
                slot_win[lo_slot][SAMPLE_LSB +: SAMPLE_W]};
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        fails++;
        $display("%0t: %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    endtask

    // One accepted slot word: fill, check the tags once, then slide or emit a frame
    task automatic take_slot(input logic [WORD_W-1:0] word);
        slot_win[win_fill] = word;
        win_fill++;
        if (win_fill < SLOTS)
            return;
        if (tag_check_on && !tags_in_order()) begin
            for (int i = 0; i < SLOTS - 1; i++)
                slot_win[i] = slot_win[i + 1];
            win_fill = SLOTS - 1;
            slides++;
            return;
        end
        beats_due.push_back(t_packed_beat'{word: join_samples(0, 1), last: 1'b0});
        beats_due.push_back(t_packed_beat'{word: join_samples(6, 7), last: 1'b0});
        beats_due.push_back(t_packed_beat'{word: join_samples(3, 9), last: 1'b1});
        win_fill = 0;
    endtask

    always @(posedge i_clk) begin
        t_packed_beat due;
        if (!i_rst_n) begin
            win_fill     = 0;
            tag_check_on = 1'b1;
            beats_due.delete();
        end else begin
            // results first: a transaction on the output never stems from this edge's input
            if (i_m_tvalid && i_m_tready) begin
                if (beats_due.size() == 0) begin
                    report_mismatch("packed word with none due", i_m_tdata, '0);
                end else begin
                    due = beats_due.pop_front();
                    checked++;
                    if (i_m_tdata !== due.word)
                        report_mismatch("packed_word", i_m_tdata, due.word);
                    if (i_m_tlast !== due.last)
                        report_mismatch("frame_last", WORD_W'(i_m_tlast), WORD_W'(due.last));
                end
            end
            if (i_s_tvalid && i_s_tready)
                take_slot(i_s_tdata);
            if (i_psel && i_penable && i_pready &&
                t_reg_idx'(i_paddr[ADDR_W-1:ADDR_LSB]) == REG_TAG_CHECK) begin
                if (i_pwrite)
                    tag_check_on = i_pwdata[0];
                else if (i_prdata !== WORD_W'(tag_check_on))
                    report_mismatch("tag_check_enable read", i_prdata, WORD_W'(tag_check_on));
            end
        end
        o_fail_count    <= fails;
        o_pending       <= beats_due.size();
        o_words_checked <= checked;
        o_slides        <= slides;
    end

endmodule

// ===== sim/tdm_channel_frame_extractor_tb.sv =====
`timescale 1ns / 1ps
// Testbench top: drives slot words and register accesses into the frame extractor.
module tdm_channel_frame_extractor_tb;
    import tcfe_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_SLOTS   = 120;
    localparam int RUN_LIMIT_NS  = 2_000_000;

    localparam logic [ADDR_W-1:0] TAG_CHECK_ADDR = ADDR_W'(int'(REG_TAG_CHECK) << ADDR_LSB);
    localparam logic [ADDR_W-1:0] SPARE_ADDR     = ADDR_W'(1 << ADDR_LSB);

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_LONG
    } t_stall;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [WORD_W-1:0] s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [WORD_W-1:0] m_axis_tdata;
    logic              m_axis_tlast;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [ADDR_W-1:0] paddr         = '0;
    logic [WORD_W-1:0] pwdata        = '0;
    logic [WORD_W-1:0] prdata;
    logic              pready;

    int     fail_count;
    int     pending;
    int     words_checked;
    int     slides;

    int     burst_left = 0;
    bit     bursty     = 1'b1;
    int     slots_sent = 0;
    int     reg_writes = 0;
    t_stall stall_mode = STALL_NONE;
    int     stall_left = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    tdm_channel_frame_extractor u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    tdm_channel_frame_extractor_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_axis_tvalid),
        .i_s_tready      (s_axis_tready),
        .i_s_tdata       (s_axis_tdata),
        .i_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .i_m_tdata       (m_axis_tdata),
        .i_m_tlast       (m_axis_tlast),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_prdata        (prdata),
        .i_pready        (pready),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words_checked (words_checked),
        .o_slides        (slides)
    );

    // Receiver back-pressure: segments of free flow, random stalls and long stalls
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall'($urandom_range(0, 2));
            stall_left = $urandom_range(8, 64);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            STALL_NONE: begin
                m_axis_tready <= 1'b1;
            end
            STALL_RANDOM: begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                m_axis_tready <= (stall_left % 8 == 0);
            end
        endcase
    end

    function automatic logic [WORD_W-1:0] with_tag(input logic [WORD_W-1:0] body,
                                                   input logic [TAG_W-1:0] tag);
        logic [WORD_W-1:0] word;
        word = body;
        word[TAG_LSB +: TAG_W] = tag;
        return word;
    endfunction

    task automatic send_slot(input logic [WORD_W-1:0] word);
        int gap;
        if (bursty && burst_left <= 0) begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        slots_sent++;
    endtask

    // Holds the sender off until every predicted packed word has arrived
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [ADDR_W-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_tag_check(input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] value);
        settle();
        apb_write(addr, value);
        apb_read(TAG_CHECK_ADDR);
        reg_writes++;
    endtask

    // Mostly aligned frames with random content, some with one bad tag, some stray words
    task automatic run_phase(input int n_slots, input int pause_at);
        int             sent;
        int             pick;
        int             bad_slot;
        int             noise_len;
        logic [TAG_W-1:0] bad_tag;
        sent = 0;
        while (sent < n_slots) begin
            if (pause_at > 0 && sent >= pause_at) begin
                pause_at = 0;
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                for (int i = 0; i < SLOTS; i++)
                    send_slot(with_tag($urandom, TAG_W'(i + 1)));
                sent += SLOTS;
            end else if (pick < 85) begin
                bad_slot = $urandom_range(0, SLOTS - 1);
                for (int i = 0; i < SLOTS; i++) begin
                    if (i == bad_slot) begin
                        do bad_tag = TAG_W'($urandom); while (bad_tag == TAG_W'(i + 1));
                        send_slot(with_tag($urandom, bad_tag));
                    end else begin
                        send_slot(with_tag($urandom, TAG_W'(i + 1)));
                    end
                end
                sent += SLOTS;
            end else begin
                noise_len = $urandom_range(1, 5);
                repeat (noise_len) send_slot($urandom);
                sent += noise_len;
            end
        end
    endtask

    initial begin
        #(RUN_LIMIT_NS);
        $display("tdm_channel_frame_extractor test failed");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-ones and all-zeros slots alternating, checking on from reset
        for (int i = 0; i < SLOTS; i++)
            send_slot(with_tag((i % 2 == 0) ? 32'hFFFF_FFFF : 32'h0000_0000, TAG_W'(i + 1)));
        // stray word ahead of a frame: one slide, then realigned
        send_slot(with_tag(32'hFFFF_FFFF, '0));
        for (int i = 0; i < SLOTS; i++)
            send_slot(with_tag($urandom, TAG_W'(i + 1)));

        // upper bits set, bit 0 clear: checking goes off
        set_tag_check(TAG_CHECK_ADDR, 32'hFFFF_FFFE);
        // no register behind this address, so checking must stay off
        set_tag_check(SPARE_ADDR, 32'h0000_0001);
        run_phase(PHASE_SLOTS, 0);

        set_tag_check(TAG_CHECK_ADDR, 32'h0000_0001);
        bursty = 1'b0;
        run_phase(PHASE_SLOTS, 0);

        set_tag_check(TAG_CHECK_ADDR, 32'h0000_0000);
        bursty = 1'b1;
        run_phase(PHASE_SLOTS, 0);

        set_tag_check(TAG_CHECK_ADDR, 32'hFFFF_FFFF);
        run_phase(PHASE_SLOTS, PHASE_SLOTS / 2);

        settle();
        $display("Sent %0d slot words, checked %0d packed words, saw %0d resync slides.",
                 slots_sent, words_checked, slides);
        $display("Tag checking toggled on and off over %0d register writes with read-back.",
                 reg_writes);
        if (fail_count == 0 && pending == 0)
            $display("tdm_channel_frame_extractor test passed");
        else
            $display("tdm_channel_frame_extractor test failed");
        $finish;
    end

endmodule
